>>> hdl/plti_pkg.sv
package plti_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;

  // Width used to clamp the point count against the table depth (depth up to 256)
  localparam int unsigned CNT_CALC_W = 9;

  // Magnitudes seen by the divider: |dx*dy| < 2^32, |den| < 2^16
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 16;
  localparam int unsigned DIV_BITS_PER_CYC = 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SAT    = 2'd1;
  localparam logic [1:0] STAT_ZERO_W = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [3:0]         entry_index;
    logic signed [15:0] abscissa;
    logic signed [15:0] ordinate;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         segment;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hdl/plti_div.sv
module plti_div (
  input  logic              clk,
  input  logic              rst_n,
  input  plti_pkg::div_req_t req,
  output plti_pkg::div_rsp_t rsp
);
  import plti_pkg::*;

  localparam int unsigned NCYC  = DIV_NUM_W / DIV_BITS_PER_CYC;
  localparam int unsigned CNT_W = $clog2(NCYC);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DEN_W:0]   rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;

  // Restoring division, a fixed number of quotient bits per cycle
  always_comb begin
    logic [DIV_DEN_W:0]   rem;
    logic [DIV_NUM_W-1:0] quo;
    rem      = rem_r;
    quo      = quo_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    if (busy_r) begin
      for (int s = 0; s < DIV_BITS_PER_CYC; s++) begin
        rem = {rem[DIV_DEN_W-1:0], quo[DIV_NUM_W-1]};
        quo = {quo[DIV_NUM_W-2:0], 1'b0};
        if (rem >= {1'b0, den_r}) begin
          rem    = rem - {1'b0, den_r};
          quo[0] = 1'b1;
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NCYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    if (req.start) begin
      rem      = '0;
      quo      = req.dividend;
      den_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
    rem_nxt = rem;
    quo_nxt = quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> hdl/piecewise_linear_table_interpolator_unit.sv
// Piecewise linear table interpolator.
// Input channel (in_valid/in_ready/in_data) carries two transaction kinds:
// a load writes breakpoint (x, y) into entry entry_index and returns nothing;
// a query looks up x against the table and returns one result transaction
// (value, segment, status) on out_valid/out_ready/out_data.
// point_count sits at APB byte address 0 (psel/penable/pwrite/paddr/pwdata);
// write it only while no query is in flight. Reads return it in prdata.
// Sequencing: a load is written to the RAM on acceptance. A query scans the
// table one entry per cycle through the synchronous breakpoint RAM, then
// fetches both segment ends, forms dx*dy and divides it by the segment width
// two quotient bits per cycle (a zero-width segment skips the divide). The
// next transaction is taken only once the sequencer is back in idle.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops any
// pending result and sets point_count to 2; table contents are not cleared.
// A stalled receiver holds the result in the output register; loads are
// still taken, and a new query is computed but holds in the finish phase
// until the pending result has been taken.
module piecewise_linear_table_interpolator_unit #(
  parameter int unsigned MAX_POINTS = plti_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plti_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plti_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import plti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam logic [CNT_CALC_W-1:0] MAXP = CNT_CALC_W'(MAX_POINTS);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SCAN     = 9'b000000010,
    ST_FETCH_HI = 9'b000000100,
    ST_FETCH_LO = 9'b000001000,
    ST_SETUP    = 9'b000010000,
    ST_MUL      = 9'b000100000,
    ST_DIVGO    = 9'b001000000,
    ST_DIV      = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  // Configuration register
  logic [4:0] point_count_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {27'b0, point_count_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 5'd2;
    end else if (cfg_wr) begin
      point_count_r <= pwdata[4:0];
    end
  end

  // Breakpoint RAM: {x, y} per entry, one write and one registered read port
  logic [31:0]   mem [MAX_POINTS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [31:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {in_data.abscissa, in_data.ordinate};
    end
    rd_data_r <= mem[mem_ra];
  end

  logic signed [15:0] rd_x, rd_y;
  assign rd_x = rd_data_r[31:16];
  assign rd_y = rd_data_r[15:0];

  // Clamp the point count into [2, MAX_POINTS]; last segment index is n-2
  logic [CNT_CALC_W-1:0] cnt_ext, n_eff;
  logic [AW-1:0]         last_now;

  always_comb begin
    cnt_ext = {{(CNT_CALC_W-5){1'b0}}, point_count_r};
    if (cnt_ext < CNT_CALC_W'(2)) begin
      n_eff = CNT_CALC_W'(2);
    end else if (cnt_ext > MAXP) begin
      n_eff = MAXP;
    end else begin
      n_eff = cnt_ext;
    end
    last_now = AW'(n_eff - CNT_CALC_W'(2));
  end

  // Query datapath registers
  logic signed [15:0] xq_r, xq_nxt;
  logic [AW-1:0]      last_r, last_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic signed [15:0] xhi_r, xhi_nxt, yhi_r, yhi_nxt;
  logic signed [15:0] ylo_r, ylo_nxt;
  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt, den_r, den_nxt;
  logic signed [33:0] num_r, num_nxt;
  logic               neg_r, neg_nxt;
  logic signed [15:0] res_value_r, res_value_nxt;
  logic [1:0]         res_status_r, res_status_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  plti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (st_r == ST_IDLE);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  logic               hit;
  logic signed [16:0] den_mag;
  logic signed [32:0] q_signed;
  logic signed [33:0] sum;

  assign hit = (xq_r < rd_x);

  always_comb begin
    den_mag  = '0;
    q_signed = '0;
    sum      = '0;

    st_nxt         = st_r;
    xq_nxt         = xq_r;
    last_nxt       = last_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    xhi_nxt        = xhi_r;
    yhi_nxt        = yhi_r;
    ylo_nxt        = ylo_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    den_nxt        = den_r;
    num_nxt        = num_r;
    neg_nxt        = neg_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    mem_we = 1'b0;
    mem_wa = AW'(in_data.entry_index);
    mem_ra = AW'(1);

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    // Drop the result once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_LOAD) begin
            // Loads beyond the table depth are ignored
            mem_we = ({{(CNT_CALC_W-4){1'b0}}, in_data.entry_index} < MAXP);
          end else begin
            // Start the scan: entry 1 arrives from the RAM next cycle
            xq_nxt   = in_data.abscissa;
            last_nxt = last_now;
            i_nxt    = '0;
            j_nxt    = '0;
            st_nxt   = (last_now == '0) ? ST_FETCH_HI : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rd_data_r holds entry i+1; speculatively request entry i+2
        mem_ra = i_r + AW'(2);
        if (hit) begin
          j_nxt  = i_r;
          st_nxt = ST_FETCH_HI;
        end else if (i_r + AW'(1) == last_r) begin
          j_nxt  = last_r;
          st_nxt = ST_FETCH_HI;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_FETCH_HI: begin
        mem_ra = j_r + AW'(1);
        st_nxt = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        mem_ra  = j_r;
        xhi_nxt = rd_x;
        yhi_nxt = rd_y;
        st_nxt  = ST_SETUP;
      end
      ST_SETUP: begin
        // rd_data_r now holds the lower breakpoint of the segment
        dx_nxt  = 17'(xq_r) - 17'(rd_x);
        dy_nxt  = 17'(yhi_r) - 17'(rd_y);
        den_nxt = 17'(xhi_r) - 17'(rd_x);
        ylo_nxt = rd_y;
        st_nxt  = ST_MUL;
      end
      ST_MUL: begin
        num_nxt = dx_r * dy_r;
        if (den_r == '0) begin
          res_value_nxt  = '0;
          res_status_nxt = STAT_ZERO_W;
          st_nxt         = ST_FINISH;
        end else begin
          st_nxt = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        // Divide magnitudes; quotient sign restored afterwards (truncates to zero)
        neg_nxt          = num_r[33] ^ den_r[16];
        den_mag          = den_r[16] ? -den_r : den_r;
        div_req.start    = 1'b1;
        div_req.dividend = num_r[33] ? DIV_NUM_W'(-num_r) : DIV_NUM_W'(num_r);
        div_req.divisor  = den_mag[DIV_DEN_W-1:0];
        st_nxt           = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          q_signed = neg_r ? -$signed({1'b0, div_rsp.quotient})
                           :  $signed({1'b0, div_rsp.quotient});
          sum      = 34'(ylo_r) + 34'(q_signed);
          if (sum > 34'sd32767) begin
            res_value_nxt  = 16'sh7FFF;
            res_status_nxt = STAT_SAT;
          end else if (sum < -34'sd32768) begin
            res_value_nxt  = -16'sh8000;
            res_status_nxt = STAT_SAT;
          end else begin
            res_value_nxt  = sum[15:0];
            res_status_nxt = STAT_OK;
          end
          st_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.value   = res_value_r;
          out_data_nxt.segment = 4'(j_r);
          out_data_nxt.status  = res_status_r;
          st_nxt               = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    xq_r         <= xq_nxt;
    last_r       <= last_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    xhi_r        <= xhi_nxt;
    yhi_r        <= yhi_nxt;
    ylo_r        <= ylo_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    den_r        <= den_nxt;
    num_r        <= num_nxt;
    neg_r        <= neg_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (st_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (i_r < last_r))
    else $error("segment scan ran past the last segment");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_FINISH))
    else $error("result loaded outside the finish phase");

  a_zero_width_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == STAT_ZERO_W)) |-> (out_data_r.value == 16'sd0))
    else $error("zero-width segment result carries a nonzero value");
`endif

endmodule
